### src/sntp_reply_validator_macros.svh
// Assertion macros for the SNTP reply validator checker.
`ifndef SNTP_REPLY_VALIDATOR_MACROS_SVH
`define SNTP_REPLY_VALIDATOR_MACROS_SVH

// same-cycle implication, held off while in reset
`define SRV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srv assertion failed");

// next-cycle implication, held off while in reset
`define SRV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srv assertion failed");

`endif

### src/srv_pkg.sv
// Types, codes and constants shared by the SNTP reply validator modules.
`timescale 1ns / 1ps

package srv_pkg;

    localparam int STRAY_LIMIT_DEFAULT = 100;

    localparam int          POS_W      = 6;
    localparam logic [5:0]  PKT_LEN    = 6'd48;
    localparam logic [5:0]  POS_LAST   = 6'd47;
    localparam logic [5:0]  POS_STRAT  = 6'd1;
    localparam logic [5:0]  POS_HDR    = 6'd0;

    localparam logic [31:0] EPOCH_DIFF = 32'd2461449600;
    localparam logic [31:0] ERA1_ADD   = 32'd1833517696;
    localparam logic [31:0] DATE_FLOOR = 32'(((22 * 365) + 5) * 86400);
    localparam logic [31:0] DATE_CEIL  = 32'(((64'd122 * 365) + 30) * 86400);

    // ticks / 100 == ((ticks >> 2) * RTT_RECIP) >> RTT_SHIFT for 23-bit ticks
    localparam int          RTT_SHIFT  = 26;
    localparam logic [21:0] RTT_RECIP  = 22'd2684355;
    localparam int          RTT_Q_W    = 17;

    localparam logic [2:0]  MODE_SERVER = 3'd4;
    localparam logic [1:0]  LEAP_ALARM  = 2'd3;
    localparam logic [7:0]  STRATUM_MAX = 8'd15;

    localparam logic [1:0]  CFG_NONCE_HIGH = 2'd0;
    localparam logic [1:0]  CFG_NONCE_LOW  = 2'd1;
    localparam logic [1:0]  CFG_SERVER     = 2'd2;
    localparam logic [1:0]  CFG_OFFSET     = 2'd3;

    typedef enum logic [2:0] {
        VERDICT_ACCEPTED = 3'd0,
        VERDICT_IGNORED  = 3'd1,
        VERDICT_UNSYNC   = 3'd2,
        VERDICT_REFUSED  = 3'd3,
        VERDICT_BAD_DATE = 3'd4,
        VERDICT_GAVE_UP  = 3'd5
    } t_verdict;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic        end_of_packet;
        logic [31:0] source_address;
        logic [22:0] round_trip_ticks;
    } t_in_word;

    typedef struct packed {
        t_verdict    verdict;
        logic [31:0] local_seconds;
    } t_out_word;

    // captured reply fields and their derived checks
    typedef struct packed {
        logic [7:0]  header;
        logic [7:0]  stratum;
        logic        nonce_ok;
        logic        date_ok;
        logic [31:0] secs78;
        logic        full;
    } t_capture;

endpackage

### src/srv_capture.sv
// Byte position counter and capture of the reply fields, with registered field checks.
`timescale 1ns / 1ps

module srv_capture (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_last,
    input  logic [63:0]       i_nonce,
    output srv_pkg::t_capture o_cap
);
    import srv_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [7:0]       r_header;
    logic [7:0]       r_stratum;
    logic [7:0][7:0]  r_echoed;
    logic [3:0][7:0]  r_seconds;
    logic             r_nonce_ok;
    logic             r_date_ok;
    logic [31:0]      r_secs78;
    logic [31:0]      w_secs;
    logic [31:0]      w_conv;

    always_comb begin
        n_pos = r_pos;
        if (r_pos < PKT_LEN) begin
            n_pos = r_pos + 1'b1;
        end
        if (i_last) begin
            n_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_accept) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && (r_pos < PKT_LEN)) begin
            if (r_pos == POS_HDR) begin
                r_header <= i_rx_byte;
            end else if (r_pos == POS_STRAT) begin
                r_stratum <= i_rx_byte;
            end else if (r_pos >= 6'd24 && r_pos <= 6'd31) begin
                r_echoed[~r_pos[2:0]] <= i_rx_byte;
            end else if (r_pos >= 6'd40 && r_pos <= 6'd43) begin
                r_seconds[~r_pos[1:0]] <= i_rx_byte;
            end
        end
    end

    // era wrap: timestamps below the 1978 epoch point belong to era 1
    assign w_secs = r_seconds;
    assign w_conv = (w_secs >= EPOCH_DIFF) ? (w_secs - EPOCH_DIFF) : (w_secs + ERA1_ADD);

    // fields settle several words before the last byte of any full-length reply
    always_ff @(posedge i_clk) begin
        r_nonce_ok <= (r_echoed == i_nonce);
        r_secs78   <= w_conv;
        r_date_ok  <= (w_secs != '0) && (w_conv >= DATE_FLOOR) && (w_conv <= DATE_CEIL);
    end

    always_comb begin
        o_cap.header   = r_header;
        o_cap.stratum  = r_stratum;
        o_cap.nonce_ok = r_nonce_ok;
        o_cap.date_ok  = r_date_ok;
        o_cap.secs78   = r_secs78;
        o_cap.full     = (r_pos >= POS_LAST);
    end

endmodule

### src/srv_judge.sv
// Last-byte stage, verdict logic, stray counter and output register.
`timescale 1ns / 1ps

module srv_judge #(
    parameter int STRAY_LIMIT = srv_pkg::STRAY_LIMIT_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  srv_pkg::t_in_word  i_in_word,
    input  logic [31:0]        i_server_address,
    input  logic [11:0]        i_offset_minutes,
    input  srv_pkg::t_capture  i_cap,
    input  logic               i_out_stall,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output srv_pkg::t_out_word o_out_word
);
    import srv_pkg::*;

    localparam int CNT_W = $clog2(STRAY_LIMIT + 1);

    logic                 r_s1_valid;
    logic                 r_s1_full;
    logic                 r_s1_src_ok;
    logic [RTT_Q_W-1:0]   r_s1_q;
    logic [31:0]          r_off60;
    logic [CNT_W-1:0]     r_stray;
    logic [CNT_W-1:0]     n_stray;
    logic                 r_out_valid;
    t_out_word            r_out_word;
    t_out_word            n_out_word;
    logic                 w_advance;
    logic                 w_ours;
    logic [20:0]          w_quarter;
    logic [42:0]          w_prod;
    logic [31:0]          w_off;

    assign w_advance  = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !w_advance;

    // ticks / 100 by reciprocal
    assign w_quarter = i_in_word.round_trip_ticks[22:2];
    assign w_prod    = w_quarter * RTT_RECIP;

    assign w_off = {{20{i_offset_minutes[11]}}, i_offset_minutes};

    always_ff @(posedge i_clk) begin
        r_off60 <= (w_off << 6) - (w_off << 2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_accept) begin
            r_s1_valid <= i_in_word.end_of_packet;
        end else if (w_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_in_word.end_of_packet) begin
            r_s1_full   <= i_cap.full;
            r_s1_src_ok <= (i_in_word.source_address == i_server_address);
            r_s1_q      <= w_prod[RTT_SHIFT +: RTT_Q_W];
        end
    end

    assign w_ours = r_s1_full && r_s1_src_ok && i_cap.nonce_ok &&
                    (i_cap.header[2:0] == MODE_SERVER);

    always_comb begin
        n_out_word.verdict       = VERDICT_IGNORED;
        n_out_word.local_seconds = '0;
        n_stray                  = '0;
        if (!w_ours) begin
            if (r_stray >= CNT_W'(STRAY_LIMIT)) begin
                n_out_word.verdict = VERDICT_GAVE_UP;
            end else begin
                n_stray = r_stray + 1'b1;
            end
        end else if (i_cap.header[7:6] == LEAP_ALARM) begin
            n_out_word.verdict = VERDICT_UNSYNC;
        end else if (i_cap.stratum == '0 || i_cap.stratum > STRATUM_MAX) begin
            n_out_word.verdict = VERDICT_REFUSED;
        end else if (!i_cap.date_ok) begin
            n_out_word.verdict = VERDICT_BAD_DATE;
        end else begin
            n_out_word.verdict       = VERDICT_ACCEPTED;
            n_out_word.local_seconds = i_cap.secs78 + 32'(r_s1_q) + r_off60;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_stray     <= '0;
        end else if (w_advance) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_stray <= n_stray;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_s1_valid) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

### src/sntp_reply_validator.sv
// Top level of the SNTP reply validator: configuration registers and stage wiring.
//
//  channel  | handshake                | word
//  ---------+--------------------------+--------------------------------
//  in       | i_in_valid / o_in_stall  | i_in_word  (t_in_word)
//  out      | o_out_valid / i_out_stall| o_out_word (t_out_word)
//  config   | i_cfg_we                 | i_cfg_index, i_cfg_data
//
// One word per cycle in when not stalled; verdicts go via last-byte and output registers.
// Reset is synchronous, active low, and clears position, stray count and valids.
// The input stalls only while a verdict is waiting in the last-byte stage and the
// output register is full and stalled.
`timescale 1ns / 1ps

module sntp_reply_validator #(
    parameter int STRAY_LIMIT = srv_pkg::STRAY_LIMIT_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  srv_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output srv_pkg::t_out_word o_out_word,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import srv_pkg::*;

    logic [31:0] r_nonce_high;
    logic [31:0] r_nonce_low;
    logic [31:0] r_server_address;
    logic [11:0] r_offset_minutes;
    logic        w_accept;
    t_capture    w_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonce_high     <= '0;
            r_nonce_low      <= '0;
            r_server_address <= '0;
            r_offset_minutes <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NONCE_HIGH: r_nonce_high     <= i_cfg_data;
                CFG_NONCE_LOW:  r_nonce_low      <= i_cfg_data;
                CFG_SERVER:     r_server_address <= i_cfg_data;
                CFG_OFFSET:     r_offset_minutes <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    assign w_accept = i_in_valid && !o_in_stall;

    srv_capture u_capture (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_rx_byte (i_in_word.rx_byte),
        .i_last    (i_in_word.end_of_packet),
        .i_nonce   ({r_nonce_high, r_nonce_low}),
        .o_cap     (w_cap)
    );

    srv_judge #(
        .STRAY_LIMIT (STRAY_LIMIT)
    ) u_judge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_in_word        (i_in_word),
        .i_server_address (r_server_address),
        .i_offset_minutes (r_offset_minutes),
        .i_cap            (w_cap),
        .i_out_stall      (i_out_stall),
        .o_in_stall       (o_in_stall),
        .o_out_valid      (o_out_valid),
        .o_out_word       (o_out_word)
    );

endmodule

### src/srv_checker.sv
// Port-level checker for the SNTP reply validator, bound to the top level.
`timescale 1ns / 1ps
`include "sntp_reply_validator_macros.svh"

module srv_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input srv_pkg::t_in_word  i_in_word,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input srv_pkg::t_out_word o_out_word
);
    import srv_pkg::*;

    `SRV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word))
    `SRV_ASSERT_IMPL(a_secs_zero, i_clk, i_rst_n, o_out_valid && (o_out_word.verdict != VERDICT_ACCEPTED), o_out_word.local_seconds == '0)
    `SRV_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)
    `SRV_ASSERT_IMPL(a_res_after_last, i_clk, i_rst_n, $rose(o_out_valid), $past(i_in_valid && !o_in_stall && i_in_word.end_of_packet, 2))

endmodule

bind sntp_reply_validator srv_checker u_srv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

### bench/tb_sntp_reply_validator.sv
// Self-checking testbench for the SNTP reply validator: reply packets in, verdicts checked.
`timescale 1ns / 1ps

module tb_sntp_reply_validator;

    import srv_pkg::*;

    localparam int          GIVE_UP_AFTER   = 100;
    localparam int          QUIET_LIMIT     = 3000;
    localparam int          HOLD_CYCLES     = 300;
    localparam logic [31:0] NTP_1978_OFFSET = 32'd2461449600;
    localparam logic [31:0] DAY_FIRST78     = 32'd694224000;
    localparam logic [31:0] DAY_LAST78      = 32'd3849984000;
    localparam logic [31:0] NTP_FIRST_DAY   = 32'd3155673600;
    localparam logic [31:0] NTP_LAST_DAY    = 32'd2016466304;

    typedef struct packed {
        logic [6:0]  len;
        logic [7:0]  header;
        logic [7:0]  stratum;
        logic        nonce_ok;
        logic        source_ok;
        logic [31:0] ntp_secs;
        logic [22:0] ticks;
        logic        typed;
        t_out_word   result;
    } t_reply_case;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_in_word    in_word   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_word   out_word;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_NONCE_HIGH;
    logic [31:0] cfg_data  = '0;

    // predictor state
    logic [5:0]  rx_pos;
    logic [7:0]  rx_header;
    logic [7:0]  rx_stratum;
    logic [63:0] rx_stamp;
    logic [31:0] rx_ntp_secs;
    int          stray_replies;
    logic [63:0] cfg_nonce;
    logic [31:0] cfg_server;
    logic [11:0] cfg_offset;

    t_out_word   expected_verdicts [$];
    logic [7:0]  reply_bytes [$];
    int          failures;
    int          sender_idle_pct;
    int          receiver_idle_pct;
    bit          hold_request;

    // directed replies; typed rows carry their verdict, the rest go to the predictor
    t_reply_case directed_replies [16] = '{
        '{7'd1,  8'hFF, 8'd0,   1'b0, 1'b0, 32'd0,             23'h7FFFFF, 1'b1,
          '{VERDICT_IGNORED, 32'd0}},
        '{7'd48, 8'hE4, 8'd1,   1'b1, 1'b1, NTP_FIRST_DAY,     23'd0,      1'b1,
          '{VERDICT_UNSYNC, 32'd0}},
        '{7'd48, 8'h24, 8'd0,   1'b1, 1'b1, NTP_FIRST_DAY,     23'd0,      1'b1,
          '{VERDICT_REFUSED, 32'd0}},
        '{7'd48, 8'h24, 8'd16,  1'b1, 1'b1, NTP_FIRST_DAY,     23'd0,      1'b1,
          '{VERDICT_REFUSED, 32'd0}},
        '{7'd48, 8'h24, 8'd255, 1'b1, 1'b1, NTP_FIRST_DAY,     23'd0,      1'b1,
          '{VERDICT_REFUSED, 32'd0}},
        '{7'd48, 8'h24, 8'd1,   1'b1, 1'b1, 32'd0,             23'd0,      1'b1,
          '{VERDICT_BAD_DATE, 32'd0}},
        '{7'd48, 8'h24, 8'd15,  1'b1, 1'b1, NTP_FIRST_DAY - 1, 23'd0,      1'b1,
          '{VERDICT_BAD_DATE, 32'd0}},
        '{7'd48, 8'h24, 8'd15,  1'b1, 1'b1, NTP_LAST_DAY + 1,  23'd0,      1'b1,
          '{VERDICT_BAD_DATE, 32'd0}},
        '{7'd48, 8'h23, 8'd1,   1'b1, 1'b1, NTP_FIRST_DAY,     23'd0,      1'b1,
          '{VERDICT_IGNORED, 32'd0}},
        '{7'd48, 8'h24, 8'd1,   1'b0, 1'b1, NTP_FIRST_DAY,     23'd0,      1'b1,
          '{VERDICT_IGNORED, 32'd0}},
        '{7'd48, 8'h24, 8'd1,   1'b1, 1'b0, NTP_FIRST_DAY,     23'd0,      1'b1,
          '{VERDICT_IGNORED, 32'd0}},
        '{7'd47, 8'h24, 8'd1,   1'b1, 1'b1, NTP_FIRST_DAY,     23'd0,      1'b1,
          '{VERDICT_IGNORED, 32'd0}},
        '{7'd48, 8'h1C, 8'd1,   1'b1, 1'b1, NTP_FIRST_DAY,     23'd0,      1'b0,
          '{VERDICT_ACCEPTED, 32'd0}},
        '{7'd48, 8'h64, 8'd15,  1'b1, 1'b1, NTP_LAST_DAY,      23'h7FFFFF, 1'b0,
          '{VERDICT_ACCEPTED, 32'd0}},
        '{7'd70, 8'hA4, 8'd2,   1'b1, 1'b1, 32'hFFFFFFFF,      23'd4320000, 1'b0,
          '{VERDICT_ACCEPTED, 32'd0}},
        '{7'd48, 8'h24, 8'd1,   1'b1, 1'b1, 32'd1,             23'd99,     1'b0,
          '{VERDICT_ACCEPTED, 32'd0}}
    };

    sntp_reply_validator #(
        .STRAY_LIMIT (GIVE_UP_AFTER)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // both eras map by one modulo-2^32 subtraction
    function automatic logic [31:0] ntp_to_1978(input logic [31:0] ntp);
        logic [31:0] s;
        if (ntp == 32'd0) return 32'd0;
        s = ntp - NTP_1978_OFFSET;
        if (s < DAY_FIRST78 || s > DAY_LAST78) return 32'd0;
        return s;
    endfunction

    function automatic bit predict_verdict(input t_in_word w, output t_out_word r);
        int          pos;
        bit          ours;
        logic [31:0] s;
        r = '0;
        r.verdict = VERDICT_IGNORED;
        pos = int'(rx_pos);
        if (pos < 48) begin
            if (pos == 0) rx_header = w.rx_byte;
            else if (pos == 1) rx_stratum = w.rx_byte;
            else if (pos >= 24 && pos <= 31) rx_stamp[(31 - pos) * 8 +: 8] = w.rx_byte;
            else if (pos >= 40 && pos <= 43) rx_ntp_secs[(43 - pos) * 8 +: 8] = w.rx_byte;
            pos++;
        end
        if (!w.end_of_packet) begin
            rx_pos = 6'(pos);
            return 1'b0;
        end
        rx_pos = '0;
        ours = pos >= 48 && w.source_address == cfg_server && rx_header[2:0] == MODE_SERVER
               && rx_stamp == cfg_nonce;
        if (!ours) begin
            if (stray_replies + 1 > GIVE_UP_AFTER) begin
                r.verdict = VERDICT_GAVE_UP;
                stray_replies = 0;
            end else begin
                stray_replies++;
            end
        end else begin
            stray_replies = 0;
            if (rx_header[7:6] == LEAP_ALARM) begin
                r.verdict = VERDICT_UNSYNC;
            end else if (rx_stratum == 8'd0 || rx_stratum > 8'd15) begin
                r.verdict = VERDICT_REFUSED;
            end else begin
                s = ntp_to_1978(rx_ntp_secs);
                if (s == 32'd0) begin
                    r.verdict = VERDICT_BAD_DATE;
                end else begin
                    s = s + 32'(w.round_trip_ticks / 100);
                    s = s + {{20{cfg_offset[11]}}, cfg_offset} * 32'd60;
                    r.verdict = VERDICT_ACCEPTED;
                    r.local_seconds = s;
                end
            end
        end
        return 1'b1;
    endfunction

    task automatic build_reply(input int len, input logic [7:0] hdr, input logic [7:0] strat,
                               input logic [63:0] stamp, input logic [31:0] ntp);
        reply_bytes.delete();
        for (int i = 0; i < len; i++) reply_bytes.push_back(8'($urandom));
        reply_bytes[0] = hdr;
        if (len > 1) reply_bytes[1] = strat;
        for (int i = 24; i < 32 && i < len; i++) reply_bytes[i] = stamp[(31 - i) * 8 +: 8];
        for (int i = 40; i < 44 && i < len; i++) reply_bytes[i] = ntp[(43 - i) * 8 +: 8];
    endtask

    // address and round trip only matter on the last byte; earlier words carry noise
    task automatic send_reply(input logic [31:0] src, input logic [22:0] ticks,
                              input bit typed, input t_out_word typed_result);
        t_in_word  w;
        t_out_word r;
        foreach (reply_bytes[i]) begin
            while ($urandom_range(0, 99) < sender_idle_pct) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            w.rx_byte          = reply_bytes[i];
            w.end_of_packet    = (i == reply_bytes.size() - 1);
            w.source_address   = w.end_of_packet ? src : 32'($urandom);
            w.round_trip_ticks = w.end_of_packet ? ticks : 23'($urandom);
            in_valid <= 1'b1;
            in_word  <= w;
            do @(posedge clk); while (in_stall);
            if (predict_verdict(w, r)) expected_verdicts.push_back(typed ? typed_result : r);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_regs(input logic [63:0] nonce, input logic [31:0] server,
                              input int offset);
        logic [1:0]  idx [4];
        logic [31:0] val [4];
        idx = '{CFG_NONCE_HIGH, CFG_NONCE_LOW, CFG_SERVER, CFG_OFFSET};
        val = '{nonce[63:32], nonce[31:0], server, offset[31:0]};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
        end
        cfg_we     <= 1'b0;
        cfg_nonce  = nonce;
        cfg_server = server;
        cfg_offset = offset[11:0];
    endtask

    task automatic run_random_phase(input int byte_budget, input bit hold_off);
        int          sent;
        int          kind;
        int          len;
        int          r;
        logic [7:0]  hdr;
        logic [7:0]  strat;
        logic [63:0] stamp;
        logic [31:0] ntp;
        logic [31:0] src;
        logic [22:0] ticks;
        t_out_word   none;
        none = '0;
        // run of one-byte strays, long enough to reach the give-up verdict
        if (hold_off) hold_request = 1'b1;
        repeat ($urandom_range(101, 110)) begin
            build_reply(1, 8'($urandom), 8'd0, 64'd0, 32'd0);
            send_reply(32'($urandom), 23'($urandom), 1'b0, none);
        end
        if (hold_off) drain();
        sent = 0;
        while (sent < byte_budget) begin
            kind  = $urandom_range(0, 99);
            len   = ($urandom_range(0, 99) < 85) ? 48 : $urandom_range(49, 90);
            hdr   = {($urandom_range(0, 9) == 0) ? LEAP_ALARM : 2'($urandom_range(0, 2)),
                     3'($urandom), MODE_SERVER};
            r     = $urandom_range(0, 19);
            strat = (r == 0) ? 8'd0 : (r == 1) ? 8'($urandom_range(16, 255))
                                               : 8'($urandom_range(1, 15));
            r     = $urandom_range(0, 19);
            ntp   = (r == 0) ? 32'd0 : (r == 1) ? 32'($urandom)
                  : 32'($urandom_range(DAY_FIRST78, DAY_LAST78)) + NTP_1978_OFFSET;
            ticks = ($urandom_range(0, 4) == 0) ? 23'($urandom)
                                                : 23'($urandom_range(0, 4320000));
            stamp = cfg_nonce;
            src   = cfg_server;
            if (kind >= 90) begin
                len = $urandom_range(1, 4);
                hdr = 8'($urandom);
                src = 32'($urandom);
            end else if (kind >= 80) begin
                len = $urandom_range(1, 47);
            end else if (kind >= 75) begin
                hdr[2:0] = MODE_SERVER + 3'($urandom_range(1, 7));
            end else if (kind >= 70) begin
                src = src ^ (32'd1 << $urandom_range(0, 31));
            end else if (kind >= 60) begin
                stamp = stamp ^ (64'd1 << $urandom_range(0, 63));
            end
            build_reply(len, hdr, strat, stamp, ntp);
            send_reply(src, ticks, 1'b0, none);
            sent += len;
        end
        drain();
    endtask

    initial begin : stimulus
        t_reply_case c;
        rx_pos        = '0;
        rx_header     = '0;
        rx_stratum    = '0;
        rx_stamp      = '0;
        rx_ntp_secs   = '0;
        stray_replies = 0;
        cfg_nonce     = '0;
        cfg_server    = '0;
        cfg_offset    = '0;
        failures      = 0;
        hold_request  = 1'b0;
        sender_idle_pct   = 10;
        receiver_idle_pct = 10;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_regs(64'hFFFFFFFF_00000000, 32'hFFFFFFFF, -1440);
        foreach (directed_replies[i]) begin
            c = directed_replies[i];
            build_reply(int'(c.len), c.header, c.stratum,
                        c.nonce_ok ? cfg_nonce : cfg_nonce ^ 64'd1, c.ntp_secs);
            send_reply(c.source_ok ? cfg_server : ~cfg_server, c.ticks, c.typed, c.result);
        end
        drain();

        sender_idle_pct   = 29;
        receiver_idle_pct = 71;
        write_regs({32'($urandom), 32'($urandom)}, 32'($urandom), 1440);
        run_random_phase(110, 1'b0);

        sender_idle_pct   = 71;
        receiver_idle_pct = 29;
        write_regs(64'h00000000_FFFFFFFF, 32'd0, 2047);
        run_random_phase(110, 1'b0);

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        write_regs({32'($urandom), 32'($urandom)}, 32'($urandom), -2048);
        run_random_phase(110, 1'b1);

        repeat (6) @(posedge clk);
        if (failures == 0 && expected_verdicts.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : result_sink
        int        hold_left;
        t_out_word want;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                if (expected_verdicts.size() == 0) begin
                    $error("verdict %0d with none expected", out_word.verdict);
                    failures++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (out_word.verdict !== want.verdict) begin
                        $error("verdict: expected %0d, got %0d", want.verdict, out_word.verdict);
                        failures++;
                    end
                    if (out_word.local_seconds !== want.local_seconds) begin
                        $error("local_seconds: expected %0d, got %0d",
                               want.local_seconds, out_word.local_seconds);
                        failures++;
                    end
                end
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
            else quiet++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/srv_pkg.sv
src/srv_capture.sv
src/srv_judge.sv
src/sntp_reply_validator.sv
src/srv_checker.sv
bench/tb_sntp_reply_validator.sv
